// ===== sv/sdsc_pkg.sv =====
package sdsc_pkg;

	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_RESPONSE_POLL_LIMIT = 2'd0,
		CFG_READY_POLL_LIMIT    = 2'd1,
		CFG_IDLE_RETRY_LIMIT    = 2'd2
	} cfg_idx_t;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_DESEL = 7'b0000010,
		PH_SEL   = 7'b0000100,
		PH_READY = 7'b0001000,
		PH_SEND  = 7'b0010000,
		PH_STUFF = 7'b0100000,
		PH_RESP  = 7'b1000000
	} phase_t;

	localparam logic OP_START   = 1'b0;
	localparam logic OP_RX_BYTE = 1'b1;

	localparam logic [7:0] CMD_FLAG      = 8'h40;
	localparam logic [7:0] CRC_CMD0      = 8'h95;
	localparam logic [7:0] CRC_CMD8      = 8'h87;
	localparam logic [7:0] CRC_OTHER     = 8'h01;
	localparam logic [7:0] IDLE_BYTE     = 8'hFF;
	localparam logic [6:0] IDX_CMD0      = 7'd0;
	localparam logic [6:0] IDX_CMD8      = 7'd8;
	localparam logic [6:0] IDX_CMD12     = 7'd12;
	localparam logic [6:0] IDX_CMD55     = 7'd55;
	localparam logic [7:0] CODE_CMD1     = 8'h01;
	localparam logic [7:0] CODE_ACMD41   = 8'hA9;
	localparam logic [7:0] R1_IDLE_MAX   = 8'h01;
	localparam logic [2:0] LAST_FRAME_IX = 3'd5;

	localparam logic [7:0]  RST_RESPONSE_POLL_LIMIT = 8'd8;
	localparam logic [15:0] RST_READY_POLL_LIMIT    = 16'd500;
	localparam logic [31:0] RST_IDLE_RETRY_LIMIT    = 32'd65535;

	typedef struct packed {
		logic        op;
		logic [7:0]  command;
		logic [31:0] argument;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic        transfer_request;
		logic [7:0]  tx_byte;
		logic        card_selected;
		logic        done_res;
		logic [7:0]  response;
	} res_t;

	typedef struct packed {
		logic [7:0]  response_poll_limit;
		logic [15:0] ready_poll_limit;
		logic [31:0] idle_retry_limit;
	} cfg_t;

	// Byte k of the six-byte command frame: command, four argument bytes, CRC.
	function automatic logic [7:0] frame_byte(input logic [6:0] idx,
	                                          input logic [31:0] arg,
	                                          input logic [2:0] k);
		logic [7:0] b;
		case (k)
			3'd0: b = {1'b0, idx} | CMD_FLAG;
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				if (idx == IDX_CMD0)
					b = CRC_CMD0;
				else if (idx == IDX_CMD8)
					b = CRC_CMD8;
				else
					b = CRC_OTHER;
			end
		endcase
		return b;
	endfunction

endpackage

// ===== sv/sdsc_in_stage.sv =====
module sdsc_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  sdsc_pkg::item_t item_d,
	input  logic           adv,
	output logic           v_s1,
	output sdsc_pkg::item_t item_s1
);

	// The stage frees up in the same cycle its word moves on.
	assign item_stall = v_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ===== sv/sdsc_seq.sv =====
module sdsc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  sdsc_pkg::item_t item_s1,
	input  sdsc_pkg::cfg_t  cfg,
	output sdsc_pkg::res_t  res
);

	sdsc_pkg::phase_t phase_q, phase_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [31:0] arg_q, arg_d;
	logic        prefix_q, prefix_d;
	logic [2:0]  byte_ix_q, byte_ix_d;
	logic [15:0] poll_q, poll_d;
	logic [31:0] retry_q, retry_d;
	logic        sel_q, sel_d;

	logic [6:0]  cur_idx;
	logic [31:0] cur_arg;
	logic        fin;
	logic [7:0]  fin_r1;
	logic [2:0]  byte_ix_inc;
	logic [15:0] poll_inc;
	logic [31:0] retry_inc;

	assign cur_idx     = prefix_q ? sdsc_pkg::IDX_CMD55 : cmd_q[6:0];
	assign cur_arg     = prefix_q ? 32'd0 : arg_q;
	assign byte_ix_inc = byte_ix_q + 3'd1;
	assign poll_inc    = poll_q + 16'd1;
	assign retry_inc   = retry_q + 32'd1;

	always_comb begin
		phase_d   = phase_q;
		cmd_d     = cmd_q;
		arg_d     = arg_q;
		prefix_d  = prefix_q;
		byte_ix_d = byte_ix_q;
		poll_d    = poll_q;
		retry_d   = retry_q;
		sel_d     = sel_q;
		fin       = 1'b0;
		fin_r1    = item_s1.rx_byte;
		res       = '0;

		if (item_s1.op == sdsc_pkg::OP_START) begin
			cmd_d     = item_s1.command;
			arg_d     = item_s1.argument;
			prefix_d  = item_s1.command[7];
			retry_d   = '0;
			byte_ix_d = '0;
			poll_d    = '0;
			sel_d     = 1'b0;
			phase_d   = sdsc_pkg::PH_DESEL;
			res.transfer_request = 1'b1;
			res.tx_byte          = sdsc_pkg::IDLE_BYTE;
		end else begin
			case (phase_q)
				sdsc_pkg::PH_DESEL: begin
					sel_d   = 1'b1;
					phase_d = sdsc_pkg::PH_SEL;
					res.transfer_request = 1'b1;
					res.tx_byte          = sdsc_pkg::IDLE_BYTE;
				end
				sdsc_pkg::PH_SEL: begin
					poll_d  = '0;
					phase_d = sdsc_pkg::PH_READY;
					res.transfer_request = 1'b1;
					res.tx_byte          = sdsc_pkg::IDLE_BYTE;
				end
				sdsc_pkg::PH_READY: begin
					poll_d = poll_inc;
					if (item_s1.rx_byte == sdsc_pkg::IDLE_BYTE) begin
						byte_ix_d = '0;
						phase_d   = sdsc_pkg::PH_SEND;
						res.transfer_request = 1'b1;
						res.tx_byte = sdsc_pkg::frame_byte(cur_idx, cur_arg, 3'd0);
					end else if (poll_inc == cfg.ready_poll_limit) begin
						// The card never came ready: release it and finish with 0xFF as the R1.
						sel_d  = 1'b0;
						fin    = 1'b1;
						fin_r1 = sdsc_pkg::IDLE_BYTE;
					end else begin
						res.transfer_request = 1'b1;
						res.tx_byte          = sdsc_pkg::IDLE_BYTE;
					end
				end
				sdsc_pkg::PH_SEND: begin
					res.transfer_request = 1'b1;
					if (byte_ix_q < sdsc_pkg::LAST_FRAME_IX) begin
						byte_ix_d   = byte_ix_inc;
						res.tx_byte = sdsc_pkg::frame_byte(cur_idx, cur_arg, byte_ix_inc);
					end else begin
						poll_d      = '0;
						phase_d     = (cur_idx == sdsc_pkg::IDX_CMD12) ?
						              sdsc_pkg::PH_STUFF : sdsc_pkg::PH_RESP;
						res.tx_byte = sdsc_pkg::IDLE_BYTE;
					end
				end
				sdsc_pkg::PH_STUFF: begin
					poll_d  = '0;
					phase_d = sdsc_pkg::PH_RESP;
					res.transfer_request = 1'b1;
					res.tx_byte          = sdsc_pkg::IDLE_BYTE;
				end
				sdsc_pkg::PH_RESP: begin
					poll_d = poll_inc;
					if (!item_s1.rx_byte[7] || poll_inc[7:0] == cfg.response_poll_limit) begin
						fin = 1'b1;
					end else begin
						res.transfer_request = 1'b1;
						res.tx_byte          = sdsc_pkg::IDLE_BYTE;
					end
				end
				default: begin
					phase_d = sdsc_pkg::PH_IDLE;
				end
			endcase

			if (fin) begin
				// An accepted CMD55 or a retried idle command starts a fresh attempt; anything else finishes.
				if (prefix_q) begin
					if (fin_r1 > sdsc_pkg::R1_IDLE_MAX) begin
						phase_d      = sdsc_pkg::PH_IDLE;
						res.done_res = 1'b1;
						res.response = fin_r1;
					end else begin
						prefix_d = 1'b0;
						sel_d    = 1'b0;
						phase_d  = sdsc_pkg::PH_DESEL;
						res.transfer_request = 1'b1;
						res.tx_byte          = sdsc_pkg::IDLE_BYTE;
					end
				end else if ((cmd_q == sdsc_pkg::CODE_CMD1 || cmd_q == sdsc_pkg::CODE_ACMD41)
				             && fin_r1 != 8'd0 && retry_inc != cfg.idle_retry_limit) begin
					retry_d  = retry_inc;
					prefix_d = cmd_q[7];
					sel_d    = 1'b0;
					phase_d  = sdsc_pkg::PH_DESEL;
					res.transfer_request = 1'b1;
					res.tx_byte          = sdsc_pkg::IDLE_BYTE;
				end else begin
					if ((cmd_q == sdsc_pkg::CODE_CMD1 || cmd_q == sdsc_pkg::CODE_ACMD41)
					    && fin_r1 != 8'd0)
						retry_d = retry_inc;
					phase_d      = sdsc_pkg::PH_IDLE;
					res.done_res = 1'b1;
					res.response = fin_r1;
				end
			end
		end

		res.card_selected = sel_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sdsc_pkg::PH_IDLE;
			cmd_q     <= '0;
			arg_q     <= '0;
			prefix_q  <= 1'b0;
			byte_ix_q <= '0;
			poll_q    <= '0;
			retry_q   <= '0;
			sel_q     <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_d;
			cmd_q     <= cmd_d;
			arg_q     <= arg_d;
			prefix_q  <= prefix_d;
			byte_ix_q <= byte_ix_d;
			poll_q    <= poll_d;
			retry_q   <= retry_d;
			sel_q     <= sel_d;
		end
	end

endmodule

// ===== sv/sdsc_out_stage.sv =====
module sdsc_out_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_s1,
	input  sdsc_pkg::res_t res_d,
	input  logic           res_stall,
	output logic           adv,
	output logic           res_valid,
	output sdsc_pkg::res_t res_q
);

	// A new word may enter whenever the held one is absent or leaving.
	assign adv = v_s1 && (!res_valid || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== sv/sd_spi_command_engine.sv =====
// SD-card SPI-mode command engine. A start word (op 0) latches a command and argument;
// every later word (op 1) carries the byte received on the previous exchange and gets back
// one result word: the next byte to send and the chip-select level, or the finished R1.
// Each input word yields exactly one result word. A new word is taken every clock while no
// held result stalls the pipe, as the sequencer decides the next byte in one pass of logic
// between the input register and the result register. A held result does not block an empty
// input register from filling. Write the limit registers only while no command is running.
module sd_spi_command_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        op,
	input  logic [7:0]  command,
	input  logic [31:0] argument,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        transfer_request,
	output logic [7:0]  tx_byte,
	output logic        card_selected,
	output logic        done_res,
	output logic [7:0]  response
);

	sdsc_pkg::cfg_t  cfg_q;
	sdsc_pkg::item_t item_d, item_s1;
	sdsc_pkg::res_t  res_d, res_q;
	logic            v_s1, adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.response_poll_limit <= sdsc_pkg::RST_RESPONSE_POLL_LIMIT;
			cfg_q.ready_poll_limit    <= sdsc_pkg::RST_READY_POLL_LIMIT;
			cfg_q.idle_retry_limit    <= sdsc_pkg::RST_IDLE_RETRY_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				sdsc_pkg::CFG_RESPONSE_POLL_LIMIT: cfg_q.response_poll_limit <= cfg_data[7:0];
				sdsc_pkg::CFG_READY_POLL_LIMIT:    cfg_q.ready_poll_limit <= cfg_data[15:0];
				sdsc_pkg::CFG_IDLE_RETRY_LIMIT:    cfg_q.idle_retry_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign item_d = '{op: op, command: command, argument: argument, rx_byte: rx_byte};

	sdsc_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_d     (item_d),
		.adv        (adv),
		.v_s1       (v_s1),
		.item_s1    (item_s1)
	);

	sdsc_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	sdsc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s1      (v_s1),
		.res_d     (res_d),
		.res_stall (res_stall),
		.adv       (adv),
		.res_valid (res_valid),
		.res_q     (res_q)
	);

	assign transfer_request = res_q.transfer_request;
	assign tx_byte          = res_q.tx_byte;
	assign card_selected    = res_q.card_selected;
	assign done_res         = res_q.done_res;
	assign response         = res_q.response;

	a_done_no_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(done_res && transfer_request))
		else $error("finished command also requests a transfer");

	a_start_deselects: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.op == sdsc_pkg::OP_START) |=>
		(transfer_request && !card_selected && tx_byte == sdsc_pkg::IDLE_BYTE))
		else $error("start word did not yield a deselect byte");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (v_s1 && res_valid && res_stall))
		else $error("input stalled while the pipe could move");

endmodule

// ===== bench/sd_spi_command_engine_tb.sv =====
module sd_spi_command_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [7:0] APP_FLAG = 8'h80;
	localparam logic [7:0] R1_READY = 8'h00;
	localparam logic [7:0] CMD_READ_BLOCK = 8'd17;

	typedef struct packed {
		sdsc_pkg::phase_t phase;
		logic [7:0]  saved_command;
		logic [31:0] saved_argument;
		logic        app_prefix;
		logic [2:0]  byte_index;
		logic [15:0] poll_count;
		logic [31:0] retry_count;
		logic [7:0]  last_response;
		logic        select_level;
	} engine_state_t;

	typedef struct packed {
		engine_state_t  after_state;
		sdsc_pkg::res_t result;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        op = sdsc_pkg::OP_RX_BYTE;
	logic [7:0]  command = '0;
	logic [31:0] argument = '0;
	logic [7:0]  rx_byte = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        transfer_request;
	logic [7:0]  tx_byte;
	logic        card_selected;
	logic        done_res;
	logic [7:0]  response;

	sdsc_pkg::cfg_t  limits = {sdsc_pkg::RST_RESPONSE_POLL_LIMIT,
	                           sdsc_pkg::RST_READY_POLL_LIMIT,
	                           sdsc_pkg::RST_IDLE_RETRY_LIMIT};
	engine_state_t   plan_state;
	engine_state_t   engine_state;
	sdsc_pkg::item_t pending_words[$];
	sdsc_pkg::res_t  expected_results[$];
	logic            no_idling = 1'b0;
	int              send_gap = 0;
	int              recv_gap = 0;
	int              error_count = 0;
	int              cycle_count = 0;

	sd_spi_command_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.command(command),
		.argument(argument),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.transfer_request(transfer_request),
		.tx_byte(tx_byte),
		.card_selected(card_selected),
		.done_res(done_res),
		.response(response)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic engine_state_t reset_state();
		engine_state_t s;
		s = '0;
		s.phase = sdsc_pkg::PH_IDLE;
		s.last_response = sdsc_pkg::IDLE_BYTE;
		return s;
	endfunction

	function automatic logic [7:0] frame_octet(engine_state_t s, logic [2:0] k);
		logic [6:0]  idx;
		logic [31:0] arg;
		idx = s.app_prefix ? sdsc_pkg::IDX_CMD55 : s.saved_command[6:0];
		arg = s.app_prefix ? 32'd0 : s.saved_argument;
		if (k == 3'd0)
			return {1'b0, idx} | sdsc_pkg::CMD_FLAG;
		if (k < sdsc_pkg::LAST_FRAME_IX)
			return 8'(arg >> (8 * (4 - int'(k))));
		if (idx == sdsc_pkg::IDX_CMD0)
			return sdsc_pkg::CRC_CMD0;
		if (idx == sdsc_pkg::IDX_CMD8)
			return sdsc_pkg::CRC_CMD8;
		return sdsc_pkg::CRC_OTHER;
	endfunction

	// One word through the sequencer: the state after it and the result word it yields.
	function automatic step_t engine_step(engine_state_t s, sdsc_pkg::cfg_t lim,
	                                      sdsc_pkg::item_t w);
		step_t      t;
		logic       finish;
		logic       again;
		logic [7:0] r1;
		t.result = '0;
		finish = 1'b0;
		again = 1'b0;
		r1 = w.rx_byte;
		if (w.op == sdsc_pkg::OP_START) begin
			s.saved_command = w.command;
			s.saved_argument = w.argument;
			s.app_prefix = w.command[7];
			s.retry_count = '0;
			s.byte_index = '0;
			s.poll_count = '0;
			again = 1'b1;
		end else begin
			if (s.phase != sdsc_pkg::PH_IDLE) begin
				t.result.transfer_request = 1'b1;
				t.result.tx_byte = sdsc_pkg::IDLE_BYTE;
			end
			case (s.phase)
				sdsc_pkg::PH_DESEL: begin
					s.select_level = 1'b1;
					s.phase = sdsc_pkg::PH_SEL;
				end
				sdsc_pkg::PH_SEL: begin
					s.poll_count = '0;
					s.phase = sdsc_pkg::PH_READY;
				end
				sdsc_pkg::PH_READY: begin
					s.poll_count = s.poll_count + 16'd1;
					if (w.rx_byte == sdsc_pkg::IDLE_BYTE) begin
						s.byte_index = '0;
						s.phase = sdsc_pkg::PH_SEND;
						t.result.tx_byte = frame_octet(s, 3'd0);
					end else if (s.poll_count == lim.ready_poll_limit) begin
						s.select_level = 1'b0;
						finish = 1'b1;
						r1 = sdsc_pkg::IDLE_BYTE;
					end
				end
				sdsc_pkg::PH_SEND: begin
					if (s.byte_index < sdsc_pkg::LAST_FRAME_IX) begin
						s.byte_index = s.byte_index + 3'd1;
						t.result.tx_byte = frame_octet(s, s.byte_index);
					end else begin
						s.poll_count = '0;
						if (!s.app_prefix && s.saved_command[6:0] == sdsc_pkg::IDX_CMD12)
							s.phase = sdsc_pkg::PH_STUFF;
						else
							s.phase = sdsc_pkg::PH_RESP;
					end
				end
				sdsc_pkg::PH_STUFF: begin
					s.poll_count = '0;
					s.phase = sdsc_pkg::PH_RESP;
				end
				sdsc_pkg::PH_RESP: begin
					s.poll_count = s.poll_count + 16'd1;
					if (!w.rx_byte[7] || s.poll_count[7:0] == lim.response_poll_limit)
						finish = 1'b1;
				end
				default: begin
					s.phase = sdsc_pkg::PH_IDLE;
				end
			endcase
		end
		if (finish) begin
			s.last_response = r1;
			if (s.app_prefix && r1 <= sdsc_pkg::R1_IDLE_MAX) begin
				s.app_prefix = 1'b0;
				again = 1'b1;
			end else if (!s.app_prefix && r1 != R1_READY &&
			             (s.saved_command == sdsc_pkg::CODE_CMD1 ||
			              s.saved_command == sdsc_pkg::CODE_ACMD41)) begin
				s.retry_count = s.retry_count + 32'd1;
				if (s.retry_count != lim.idle_retry_limit) begin
					s.app_prefix = s.saved_command[7];
					again = 1'b1;
				end
			end
			if (!again) begin
				s.phase = sdsc_pkg::PH_IDLE;
				t.result.transfer_request = 1'b0;
				t.result.tx_byte = '0;
				t.result.done_res = 1'b1;
				t.result.response = r1;
			end
		end
		if (again) begin
			s.select_level = 1'b0;
			s.phase = sdsc_pkg::PH_DESEL;
			t.result.transfer_request = 1'b1;
			t.result.tx_byte = sdsc_pkg::IDLE_BYTE;
		end
		t.result.card_selected = s.select_level;
		t.after_state = s;
		return t;
	endfunction

	// What a card might plausibly return at each point of the exchange.
	function automatic logic [7:0] card_byte(sdsc_pkg::phase_t ph);
		int pick;
		pick = $urandom_range(0, 99);
		if (ph == sdsc_pkg::PH_READY)
			return (pick < 70) ? sdsc_pkg::IDLE_BYTE : 8'($urandom_range(0, 254));
		if (ph == sdsc_pkg::PH_RESP) begin
			if (pick < 25)
				return R1_READY;
			if (pick < 45)
				return sdsc_pkg::R1_IDLE_MAX;
			if (pick < 60)
				return 8'($urandom_range(2, 127));
			return 8'($urandom_range(128, 255));
		end
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 9))
			0: return {1'b0, sdsc_pkg::IDX_CMD0};
			1: return {1'b0, sdsc_pkg::IDX_CMD8};
			2: return {1'b0, sdsc_pkg::IDX_CMD12};
			3: return sdsc_pkg::CODE_CMD1;
			4: return sdsc_pkg::CODE_ACMD41;
			5: return sdsc_pkg::CMD_FLAG | 8'($urandom_range(0, 63));
			6: return APP_FLAG | 8'($urandom_range(0, 63));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_argument();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// The planning copy of the state only steers what the card says next.
	task automatic queue_word(logic o, logic [7:0] c, logic [31:0] a, logic [7:0] r);
		sdsc_pkg::item_t w;
		step_t t;
		w = {o, c, a, r};
		t = engine_step(plan_state, limits, w);
		plan_state = t.after_state;
		pending_words.push_back(w);
	endtask

	task automatic run_command(logic [7:0] code, logic [31:0] arg, int busy_polls,
	                           logic [7:0] r1);
		logic [7:0] rx;
		queue_word(sdsc_pkg::OP_START, code, arg, 8'h00);
		while (plan_state.phase != sdsc_pkg::PH_IDLE) begin
			rx = sdsc_pkg::IDLE_BYTE;
			if (plan_state.phase == sdsc_pkg::PH_READY && busy_polls > 0) begin
				rx = 8'h00;
				busy_polls--;
			end else if (plan_state.phase == sdsc_pkg::PH_RESP) begin
				rx = r1;
			end
			queue_word(sdsc_pkg::OP_RX_BYTE, 8'($urandom), $urandom, rx);
		end
	endtask

	task automatic random_traffic(int count);
		int n;
		n = 0;
		while (n < count) begin
			if (plan_state.phase == sdsc_pkg::PH_IDLE) begin
				if ($urandom_range(0, 9) < 8) begin
					queue_word(sdsc_pkg::OP_START, pick_command(), pick_argument(),
					           8'($urandom));
					n++;
				end else begin
					queue_word(sdsc_pkg::OP_RX_BYTE, 8'($urandom), $urandom, 8'($urandom));
				end
			end else begin
				// Now and then a new command cuts the running one short.
				if ($urandom_range(0, 99) < 2)
					queue_word(sdsc_pkg::OP_START, pick_command(), pick_argument(),
					           8'($urandom));
				else
					queue_word(sdsc_pkg::OP_RX_BYTE, 8'($urandom), $urandom,
					           card_byte(plan_state.phase));
				n++;
			end
		end
	endtask

	task automatic write_limit(sdsc_pkg::cfg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			sdsc_pkg::CFG_RESPONSE_POLL_LIMIT: limits.response_poll_limit = value[7:0];
			sdsc_pkg::CFG_READY_POLL_LIMIT: limits.ready_poll_limit = value[15:0];
			default: limits.idle_retry_limit = value;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(logic [7:0] resp_polls, logic [15:0] ready_polls,
	                          logic [31:0] retries);
		write_limit(sdsc_pkg::CFG_RESPONSE_POLL_LIMIT, {24'd0, resp_polls});
		write_limit(sdsc_pkg::CFG_READY_POLL_LIMIT, {16'd0, ready_polls});
		write_limit(sdsc_pkg::CFG_IDLE_RETRY_LIMIT, retries);
	endtask

	// Sampled at the falling edge so that the driver's updates have all landed.
	task automatic settle();
		while (pending_words.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : driver
		step_t t;
		sdsc_pkg::item_t w;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				t = engine_step(engine_state, limits, {op, command, argument, rx_byte});
				engine_state = t.after_state;
				expected_results.push_back(t.result);
			end
			if (!item_valid || !item_stall) begin
				if (send_gap != 0 && !no_idling) begin
					item_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_words.size() != 0) begin
					w = pending_words.pop_front();
					op <= w.op;
					command <= w.command;
					argument <= w.argument;
					rx_byte <= w.rx_byte;
					item_valid <= 1'b1;
					if (!no_idling && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 4);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		sdsc_pkg::res_t oldest;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result word with none expected, tx %0h response %0h",
					         $time, tx_byte, response);
					error_count++;
				end else begin
					oldest = expected_results.pop_front();
					check_field("transfer_request", 32'(oldest.transfer_request),
					            32'(transfer_request));
					check_field("tx_byte", 32'(oldest.tx_byte), 32'(tx_byte));
					check_field("card_selected", 32'(oldest.card_selected),
					            32'(card_selected));
					check_field("done_res", 32'(oldest.done_res), 32'(done_res));
					check_field("response", 32'(oldest.response), 32'(response));
				end
			end
			if (no_idling) begin
				res_stall <= 1'b0;
				recv_gap <= 0;
			end else if (recv_gap != 0) begin
				res_stall <= 1'b1;
				recv_gap <= recv_gap - 1;
			end else if ($urandom_range(0, 11) == 0) begin
				res_stall <= 1'b1;
				recv_gap <= $urandom_range(0, 3);
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out with %0d result words outstanding", expected_results.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		plan_state = reset_state();
		engine_state = reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Idle noise, a plain CMD0 with one busy poll, then CMD8 cut short by CMD12.
		queue_word(sdsc_pkg::OP_RX_BYTE, 8'hFF, 32'hFFFF_FFFF, 8'h00);
		run_command({1'b0, sdsc_pkg::IDX_CMD0}, 32'd0, 1, sdsc_pkg::R1_IDLE_MAX);
		queue_word(sdsc_pkg::OP_START, {1'b0, sdsc_pkg::IDX_CMD8}, 32'h0000_01AA, 8'h00);
		queue_word(sdsc_pkg::OP_RX_BYTE, 8'h00, 32'd0, sdsc_pkg::IDLE_BYTE);
		queue_word(sdsc_pkg::OP_RX_BYTE, 8'h00, 32'd0, sdsc_pkg::IDLE_BYTE);
		run_command({1'b0, sdsc_pkg::IDX_CMD12}, 32'hFFFF_FFFF, 0, R1_READY);
		random_traffic(100);
		settle();

		set_limits(8'd1, 16'd1, 32'd1);
		random_traffic(80);
		settle();

		set_limits(8'd3, 16'd2, 32'd3);
		random_traffic(100);
		settle();

		set_limits(8'd255, 16'd65535, 32'hFFFF_FFFF);
		random_traffic(100);
		settle();

		// With every limit at zero the counters wrap: a silent card is polled 256 times.
		set_limits(8'd0, 16'd0, 32'd0);
		run_command(CMD_READ_BLOCK, $urandom, 0, sdsc_pkg::IDLE_BYTE);
		random_traffic(75);
		settle();

		set_limits(8'($urandom_range(1, 6)), 16'($urandom_range(1, 6)), $urandom_range(1, 5));
		random_traffic(100);
		settle();
		no_idling = 1'b1;
		random_traffic(100);
		settle();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
